/* src/servo_goal_position_packet_assert.svh */
// Assertion macros for the servo packet block.
`ifndef SERVO_GOAL_POSITION_PACKET_ASSERT_SVH
`define SERVO_GOAL_POSITION_PACKET_ASSERT_SVH

`ifndef SYNTHESIS
`define SGP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SGP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SGP_ASSERT(lbl, clk, rst, prop, msg)
`define SGP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* src/sgp_pkg.sv */
package sgp_pkg;

  // field widths
  localparam int ANGLE_W   = 9;
  localparam int SPEED_W   = 10;
  localparam int PCT_W     = 7;
  localparam int ID_W      = 8;
  localparam int WPOS_W    = 12;
  localparam int GPOS_W    = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;

  // packet layout
  localparam int PKT_MAX = 11;
  localparam int LEN_W   = 4;
  localparam logic [LEN_W-1:0] PKT_LEN_WRIST   = 4'd11;
  localparam logic [LEN_W-1:0] PKT_LEN_GRIPPER = 4'd9;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] INSTR_WRITE = 8'd3;
  localparam logic [7:0] ADDR_GOAL   = 8'd30;
  localparam logic [7:0] LEN_WRIST   = 8'd7;
  localparam logic [7:0] LEN_GRIPPER = 8'd5;

  // 4095/360 is exactly 91/8
  localparam int DEG_MUL   = 91;
  localparam int DEG_SHIFT = 3;
  localparam int CNT_W     = 13;

  // divide by 100 via reciprocal, exact for products below 2^17
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam int PROD_W      = 17;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_K     = ((1 << RECIP_SHIFT) + 99) / 100;
  localparam int RECIP_W     = PROD_W + 18;

  typedef enum logic {
    ACT_WRIST   = 1'b0,
    ACT_GRIPPER = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WRIST_ID   = 3'd0,
    REG_GRIP_ID    = 3'd1,
    REG_WRIST_HOME = 3'd2,
    REG_WRIST_MIN  = 3'd3,
    REG_WRIST_MAX  = 3'd4,
    REG_GRIP_MIN   = 3'd5,
    REG_GRIP_MAX   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [ID_W-1:0]   wrist_id;
    logic [ID_W-1:0]   grip_id;
    logic [WPOS_W-1:0] wrist_home;
    logic [WPOS_W-1:0] wrist_min;
    logic [WPOS_W-1:0] wrist_max;
    logic [GPOS_W-1:0] grip_min;
    logic [GPOS_W-1:0] grip_max;
  } cfg_regs_t;

  typedef struct packed {
    logic               action;
    logic [ANGLE_W-1:0] angle;
    logic [SPEED_W-1:0] speed;
    logic [PCT_W-1:0]   pct;
  } cmd_t;

  typedef struct packed {
    logic [PKT_MAX-1:0][7:0] data;
    logic [LEN_W-1:0]        len;
  } pkt_t;

endpackage

/* src/sgp_if.sv */
interface sgp_cmd_if import sgp_pkg::*;;
  logic               valid;
  logic               ready;
  logic               action;
  logic [ANGLE_W-1:0] angle_degrees;
  logic [SPEED_W-1:0] move_speed;
  logic [PCT_W-1:0]   activation_percent;

  modport source (output valid, action, angle_degrees, move_speed, activation_percent,
                  input ready);
  modport sink   (input valid, action, angle_degrees, move_speed, activation_percent,
                  output ready);
endinterface

interface sgp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, tx_byte, last_byte, input ready);
  modport sink   (input valid, tx_byte, last_byte, output ready);
endinterface

interface sgp_cfg_if import sgp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/sgp_map.sv */
// Two-stage position mapping and packet assembly.
module sgp_map import sgp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg,
  input  cmd_t      cmd,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  output pkt_t      pkt,
  output logic      pkt_valid,
  input  logic      pkt_ready
);

  typedef struct packed {
    logic               action;
    logic [WPOS_W-1:0]  wrist_pos;
    logic [SPEED_W-1:0] speed;
    logic [PROD_W-1:0]  grip_prod;
    logic               span_neg;
  } mid_t;

  logic s1_valid;
  cmd_t s1;
  logic s2_valid;
  mid_t s2;

  logic s2_take;
  logic s1_move;

  // stage 1 combinational
  logic [PCT_W-1:0]          pct_sat;
  logic signed [GPOS_W:0]    span;
  logic [GPOS_W-1:0]         span_mag;
  logic [15:0]               deg_scaled;
  logic [CNT_W-1:0]          count;
  logic signed [WPOS_W+1:0]  diff;
  logic signed [WPOS_W+1:0]  lim_lo;
  logic signed [WPOS_W+1:0]  lim_hi;
  mid_t                      mid_next;

  // stage 2 combinational
  logic [RECIP_W-1:0] recip;
  logic [GPOS_W-1:0]  quot;
  logic [GPOS_W-1:0]  grip_pos;
  logic [15:0]        pos16;
  logic [7:0]         id_b;
  logic [7:0]         len_b;
  logic [7:0]         spd_lo;
  logic [7:0]         spd_hi;
  logic [7:0]         sum;
  logic [7:0]         cks;
  logic               is_wrist;

  assign s2_take   = !s2_valid || pkt_ready;
  assign s1_move   = s1_valid && s2_take;
  assign cmd_ready = !s1_valid || s2_take;
  assign pkt_valid = s2_valid;

  always_comb begin
    pct_sat  = (s1.pct > PCT_FULL) ? PCT_FULL : s1.pct;
    span     = $signed({1'b0, cfg.grip_max}) - $signed({1'b0, cfg.grip_min});
    span_mag = span[GPOS_W] ? GPOS_W'(-span) : span[GPOS_W-1:0];

    deg_scaled = 16'(s1.angle) * 16'(DEG_MUL);
    count      = deg_scaled[15:DEG_SHIFT];
    diff   = $signed({2'b00, cfg.wrist_home}) - $signed({1'b0, count});
    lim_lo = $signed({2'b00, cfg.wrist_min});
    lim_hi = $signed({2'b00, cfg.wrist_max});

    mid_next.action    = s1.action;
    mid_next.speed     = s1.speed;
    mid_next.span_neg  = span[GPOS_W];
    mid_next.grip_prod = PROD_W'(pct_sat) * PROD_W'(span_mag);
    // min test wins when limits are crossed
    if (diff < lim_lo) begin
      mid_next.wrist_pos = cfg.wrist_min;
    end else if (diff > lim_hi) begin
      mid_next.wrist_pos = cfg.wrist_max;
    end else begin
      mid_next.wrist_pos = diff[WPOS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (cmd_ready) begin
        s1_valid <= cmd_valid;
      end
      if (s2_take) begin
        s2_valid <= s1_valid;
      end
    end
    if (cmd_ready && cmd_valid) begin
      s1 <= cmd;
    end
    if (s1_move) begin
      s2 <= mid_next;
    end
  end

  always_comb begin
    is_wrist = (s2.action == ACT_WRIST);
    recip    = RECIP_W'(s2.grip_prod) * RECIP_W'(RECIP_K);
    quot     = recip[RECIP_SHIFT+GPOS_W-1:RECIP_SHIFT];
    // result stays inside the limits, so 10 bits never wrap
    grip_pos = s2.span_neg ? (cfg.grip_min - quot) : (cfg.grip_min + quot);

    pos16  = is_wrist ? 16'(s2.wrist_pos) : 16'(grip_pos);
    id_b   = is_wrist ? cfg.wrist_id : cfg.grip_id;
    len_b  = is_wrist ? LEN_WRIST : LEN_GRIPPER;
    spd_lo = s2.speed[7:0];
    spd_hi = 8'(s2.speed[SPEED_W-1:8]);

    sum = id_b + len_b + INSTR_WRITE + ADDR_GOAL + pos16[7:0] + pos16[15:8];
    if (is_wrist) begin
      sum = sum + spd_lo + spd_hi;
    end
    cks = ~sum;

    pkt.data[0] = HEADER_BYTE;
    pkt.data[1] = HEADER_BYTE;
    pkt.data[2] = id_b;
    pkt.data[3] = len_b;
    pkt.data[4] = INSTR_WRITE;
    pkt.data[5] = ADDR_GOAL;
    pkt.data[6] = pos16[7:0];
    pkt.data[7] = pos16[15:8];
    if (is_wrist) begin
      pkt.data[8]  = spd_lo;
      pkt.data[9]  = spd_hi;
      pkt.data[10] = cks;
      pkt.len      = PKT_LEN_WRIST;
    end else begin
      pkt.data[8]  = cks;
      pkt.data[9]  = 8'h00;
      pkt.data[10] = 8'h00;
      pkt.len      = PKT_LEN_GRIPPER;
    end
  end

endmodule

/* src/servo_goal_position_packet.sv */
// Servo goal-position packet builder.
// cmd: one transaction per command. action 0 = wrist move (angle_degrees,
//   move_speed), action 1 = gripper move (activation_percent).
// tx:  one transaction per packet byte; last_byte marks the checksum byte.
//   Wrist packets are 11 bytes, gripper packets 9 bytes.
// cfg: register writes (index 0..6: ids, wrist home/min/max, gripper min/max);
//   always ready. Other indexes ignored. The user must see that registers are
//   only written while the block is idle; the block does not enforce it.
// A command passes the input register, the mapping register, then the byte
//   shift register before its first byte shows on tx.
// tx carries one byte per cycle while tx.ready is high; the serializer is
//   the limit. Two commands can queue in the pipeline while a packet drains.
// Reset (synchronous, rst high): pipeline and serializer empty, config
//   registers back to their defaults (ids 1 and 2, home 2048, full limits).
// A stall on tx holds the current byte; the pipeline fills, then cmd.ready
//   drops until the packet moves on.
`include "servo_goal_position_packet_assert.svh"

module servo_goal_position_packet import sgp_pkg::*; (
  input logic      clk,
  input logic      rst,
  sgp_cfg_if.sink  cfg,
  sgp_cmd_if.sink  cmd,
  sgp_byte_if.source tx
);

  cfg_regs_t regs;
  cmd_t      cmd_item;
  pkt_t      pkt;
  logic      pkt_valid;
  logic      pkt_ready;
  logic      load;
  logic      tx_fire;

  // byte shift register: sh[0] is on the bus, rem counts bytes left
  logic [PKT_MAX-1:0][7:0] sh;
  logic [LEN_W-1:0]        rem;

  // --- configuration registers ---
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.wrist_id   <= 8'd1;
      regs.grip_id    <= 8'd2;
      regs.wrist_home <= 12'd2048;
      regs.wrist_min  <= 12'd0;
      regs.wrist_max  <= 12'd4095;
      regs.grip_min   <= 10'd0;
      regs.grip_max   <= 10'd1023;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WRIST_ID:   regs.wrist_id   <= cfg.data[ID_W-1:0];
        REG_GRIP_ID:    regs.grip_id    <= cfg.data[ID_W-1:0];
        REG_WRIST_HOME: regs.wrist_home <= cfg.data[WPOS_W-1:0];
        REG_WRIST_MIN:  regs.wrist_min  <= cfg.data[WPOS_W-1:0];
        REG_WRIST_MAX:  regs.wrist_max  <= cfg.data[WPOS_W-1:0];
        REG_GRIP_MIN:   regs.grip_min   <= cfg.data[GPOS_W-1:0];
        REG_GRIP_MAX:   regs.grip_max   <= cfg.data[GPOS_W-1:0];
        default: ;
      endcase
    end
  end

  // --- mapping pipeline ---
  assign cmd_item.action = cmd.action;
  assign cmd_item.angle  = cmd.angle_degrees;
  assign cmd_item.speed  = cmd.move_speed;
  assign cmd_item.pct    = cmd.activation_percent;

  sgp_map u_map (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .cmd       (cmd_item),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .pkt       (pkt),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready)
  );

  // --- serializer ---
  assign tx.valid     = (rem != '0);
  assign tx.tx_byte   = sh[0];
  assign tx.last_byte = (rem == LEN_W'(1));
  assign tx_fire      = tx.valid && tx.ready;
  // next packet loads in the same cycle the checksum byte leaves
  assign pkt_ready    = !tx.valid || (tx_fire && tx.last_byte);
  assign load         = pkt_valid && pkt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= pkt.len;
    end else if (tx_fire) begin
      rem <= rem - LEN_W'(1);
    end
    if (load) begin
      sh <= pkt.data;
    end else if (tx_fire) begin
      sh <= {8'h00, sh[PKT_MAX-1:1]};
    end
  end

  // --- checks ---
  `SGP_ASSERT(a_rem_bound, clk, rst, rem <= PKT_LEN_WRIST, "byte count above packet size")
  `SGP_ASSERT_NEXT(a_no_gap, clk, rst, tx_fire && !tx.last_byte, tx.valid, "gap inside packet")
  `SGP_ASSERT_NEXT(a_header, clk, rst, load, tx.valid && tx.tx_byte == HEADER_BYTE, "no header")

endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sgp_pkg::*;

  // Protocol 1.0 write-instruction framing, kept apart from the package so a
  // wrong package constant shows up as a mismatch.
  localparam logic [7:0] PKT_HDR         = 8'hFF;
  localparam logic [7:0] PKT_LEN_WR      = 8'd7;
  localparam logic [7:0] PKT_LEN_GR      = 8'd5;
  localparam logic [7:0] PKT_INSTR_WRITE = 8'd3;
  localparam logic [7:0] PKT_ADDR_GOAL   = 8'd30;

  // Degree-to-count and percent scaling.
  localparam int COUNT_SPAN = 4095;
  localparam int DEG_SPAN   = 360;
  localparam int PCT_SPAN   = 100;

  // Index outside the register map; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  localparam int DRAIN_CYCLES  = 6;   // pipeline depth is two stages plus output
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEMS_PER_SET = 36;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } bus_byte_t;

  // Predicts the byte stream on tx from accepted commands and the register
  // shadow, and checks each transaction on tx against it in order.
  class goal_packet_scoreboard;
    logic [7:0]  wrist_id;
    logic [7:0]  grip_id;
    logic [11:0] wrist_home;
    logic [11:0] wrist_min;
    logic [11:0] wrist_max;
    logic [9:0]  grip_min;
    logic [9:0]  grip_max;
    bus_byte_t   pending_bytes[$];
    int          mismatches;

    function new();
      wrist_id   = 8'd1;
      grip_id    = 8'd2;
      wrist_home = 12'd2048;
      wrist_min  = 12'd0;
      wrist_max  = 12'd4095;
      grip_min   = 10'd0;
      grip_max   = 10'd1023;
      mismatches = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] value);
      case (index)
        REG_WRIST_ID:   wrist_id   = value[7:0];
        REG_GRIP_ID:    grip_id    = value[7:0];
        REG_WRIST_HOME: wrist_home = value[11:0];
        REG_WRIST_MIN:  wrist_min  = value[11:0];
        REG_WRIST_MAX:  wrist_max  = value[11:0];
        REG_GRIP_MIN:   grip_min   = value[9:0];
        REG_GRIP_MAX:   grip_max   = value[9:0];
        default: ;
      endcase
    endfunction

    function void note_command(action_t act, logic [ANGLE_W-1:0] angle,
                               logic [SPEED_W-1:0] speed, logic [PCT_W-1:0] pct);
      logic [7:0] body [8];
      logic [7:0] sum;
      int         n;
      int         count;
      int         pos;
      int         span;
      int         pct_sat;
      if (act == ACT_WRIST) begin
        // min test first, so an inverted window pins low values to min
        count = int'(angle) * COUNT_SPAN / DEG_SPAN;
        pos   = int'(wrist_home) - count;
        if (pos < int'(wrist_min)) pos = int'(wrist_min);
        else if (pos > int'(wrist_max)) pos = int'(wrist_max);
        body[0] = wrist_id;
        body[1] = PKT_LEN_WR;
        body[6] = speed[7:0];
        body[7] = {6'd0, speed[9:8]};
        n = 8;
      end else begin
        // signed span; division truncates toward zero
        pct_sat = (int'(pct) > PCT_SPAN) ? PCT_SPAN : int'(pct);
        span    = int'(grip_max) - int'(grip_min);
        pos     = int'(grip_min) + (pct_sat * span) / PCT_SPAN;
        body[0] = grip_id;
        body[1] = PKT_LEN_GR;
        n = 6;
      end
      body[2] = PKT_INSTR_WRITE;
      body[3] = PKT_ADDR_GOAL;
      body[4] = pos[7:0];
      body[5] = pos[15:8];
      pending_bytes.push_back('{PKT_HDR, 1'b0});
      pending_bytes.push_back('{PKT_HDR, 1'b0});
      sum = 8'd0;
      for (int i = 0; i < n; i++) begin
        sum += body[i];
        pending_bytes.push_back('{body[i], 1'b0});
      end
      pending_bytes.push_back('{~sum, 1'b1});
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      bus_byte_t want;
      if (pending_bytes.size() == 0) begin
        $error("tx_byte expected none actual 0x%02h (last_byte %0b)", data, last);
        mismatches++;
        return;
      end
      want = pending_bytes.pop_front();
      if (data !== want.data) begin
        $error("tx_byte expected 0x%02h actual 0x%02h", want.data, data);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_byte expected %0b actual %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  int   sender_idle_pct;
  int   receiver_idle_pct;

  goal_packet_scoreboard scoreboard;

  sgp_cfg_if  cfg_if();
  sgp_cmd_if  cmd_if();
  sgp_byte_if tx_if();

  servo_goal_position_packet u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .cmd (cmd_if),
    .tx  (tx_if)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or lost bytes end the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** servo_goal_position_packet: FAILED **");
      $finish;
    end
  end

  // Byte sink: check every tx transaction, then pick the next ready value.
  // Values read here are the ones settled before this edge.
  always @(posedge clk) begin
    if (!rst && tx_if.valid && tx_if.ready)
      scoreboard.check_byte(tx_if.tx_byte, tx_if.last_byte);
    tx_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // One register write; valid is left high so back-to-back writes never
  // lower and raise it in the same step. The caller drops it afterwards.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    scoreboard.note_config(index, value);
  endtask

  // Full register set plus a write to the unmapped index, which must be a no-op.
  task automatic set_config(logic [CFG_DAT_W-1:0] w_id, logic [CFG_DAT_W-1:0] g_id,
                            logic [CFG_DAT_W-1:0] home, logic [CFG_DAT_W-1:0] w_lo,
                            logic [CFG_DAT_W-1:0] w_hi, logic [CFG_DAT_W-1:0] g_lo,
                            logic [CFG_DAT_W-1:0] g_hi);
    cfg_write(REG_WRIST_ID, w_id);
    cfg_write(REG_GRIP_ID, g_id);
    cfg_write(REG_WRIST_HOME, home);
    cfg_write(REG_WRIST_MIN, w_lo);
    cfg_write(REG_WRIST_MAX, w_hi);
    cfg_write(REG_GRIP_MIN, g_lo);
    cfg_write(REG_GRIP_MAX, g_hi);
    cfg_write(CFG_IDX_SPARE, 12'($urandom_range(4095)));
    cfg_if.valid <= 1'b0;
  endtask

  // Command source with random gaps. Valid stays up after acceptance; the next
  // call either drops it for a gap or presents the next command.
  task automatic send_command(action_t act, logic [ANGLE_W-1:0] angle,
                              logic [SPEED_W-1:0] speed, logic [PCT_W-1:0] pct);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid              <= 1'b1;
    cmd_if.action             <= act;
    cmd_if.angle_degrees      <= angle;
    cmd_if.move_speed         <= speed;
    cmd_if.activation_percent <= pct;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    scoreboard.note_command(act, angle, speed, pct);
  endtask

  // Mostly in-range values; some angles past 360 and percents past 100 so
  // every input bit toggles.
  task automatic send_random_command();
    action_t            act;
    logic [ANGLE_W-1:0] angle;
    logic [SPEED_W-1:0] speed;
    logic [PCT_W-1:0]   pct;
    act   = $urandom_range(1) ? ACT_GRIPPER : ACT_WRIST;
    angle = ($urandom_range(4) == 0) ? ANGLE_W'($urandom_range(511))
                                     : ANGLE_W'($urandom_range(DEG_SPAN));
    speed = SPEED_W'($urandom_range(1023));
    pct   = ($urandom_range(6) == 0) ? PCT_W'($urandom_range(127))
                                     : PCT_W'($urandom_range(PCT_SPAN));
    send_command(act, angle, speed, pct);
  endtask

  // Drop valid and let every predicted byte come out, so the block is idle
  // before the registers move.
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    while (scoreboard.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    scoreboard                = new();
    cycle_count               = 0;
    sender_idle_pct           = 0;
    receiver_idle_pct         = 0;
    rst                       = 1'b1;
    cfg_if.valid              = 1'b0;
    cfg_if.index              = '0;
    cfg_if.data               = '0;
    cmd_if.valid              = 1'b0;
    cmd_if.action             = 1'b0;
    cmd_if.angle_degrees      = '0;
    cmd_if.move_speed         = '0;
    cmd_if.activation_percent = '0;
    tx_if.ready               = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset register values, no gaps.
    send_command(ACT_WRIST, 9'd0, 10'd0, 7'd0);        // home unchanged
    send_command(ACT_WRIST, 9'd360, 10'd1023, 7'd0);   // home minus count < 0 -> min
    send_command(ACT_WRIST, 9'd511, 10'h2AA, 7'd127);  // angle past full turn
    send_command(ACT_WRIST, 9'd180, 10'h155, 7'd0);
    send_command(ACT_WRIST, 9'd1, 10'd512, 7'd0);
    send_command(ACT_GRIPPER, 9'd0, 10'd0, 7'd0);
    send_command(ACT_GRIPPER, 9'd511, 10'd1023, 7'd100);
    send_command(ACT_GRIPPER, 9'd0, 10'd0, 7'd127);    // saturates at 100 percent
    send_command(ACT_GRIPPER, 9'd0, 10'd0, 7'd50);
    send_command(ACT_GRIPPER, 9'd0, 10'd0, 7'd1);
    wait_idle();

    // Directed: ids 254/255, inverted wrist window, inverted gripper span.
    set_config(12'd254, 12'd255, 12'd4095, 12'd3000, 12'd1000, 12'd1000, 12'd23);
    send_command(ACT_WRIST, 9'd0, 10'd7, 7'd0);        // above max -> max
    send_command(ACT_WRIST, 9'd360, 10'd300, 7'd0);    // below min -> min
    send_command(ACT_WRIST, 9'd90, 10'd1023, 7'd0);
    send_command(ACT_GRIPPER, 9'd0, 10'd0, 7'd0);
    send_command(ACT_GRIPPER, 9'd0, 10'd0, 7'd33);     // negative product truncates
    send_command(ACT_GRIPPER, 9'd0, 10'd0, 7'd100);
    send_command(ACT_GRIPPER, 9'd0, 10'd0, 7'd127);
    wait_idle();

    // Random sets. Idle pattern: sender sparse / sink heavy, then the reverse,
    // then back-to-back traffic.
    for (int set_num = 0; set_num < 6; set_num++) begin
      case (set_num)
        0: set_config(12'd0, 12'd253, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd1023);
        1: set_config(12'hF01, 12'd77, 12'd4095, 12'd0, 12'd4095, 12'd1023, 12'd1023);
        5: set_config(12'd1, 12'd2, 12'd2048, 12'd0, 12'd4095, 12'd0, 12'd1023);
        default: set_config(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                            12'($urandom_range(4095)), 12'($urandom_range(4095)),
                            12'($urandom_range(4095)), 12'($urandom_range(4095)),
                            12'($urandom_range(4095)));
      endcase
      if (set_num < 2) begin
        sender_idle_pct   = 11;
        receiver_idle_pct = 88;
      end else if (set_num < 4) begin
        sender_idle_pct   = 88;
        receiver_idle_pct = 11;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      repeat (ITEMS_PER_SET) send_random_command();
      wait_idle();
    end

    // Catch any stray bytes after the last packet.
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (scoreboard.mismatches == 0)
      $display("** servo_goal_position_packet: PASSED **");
    else
      $display("** servo_goal_position_packet: FAILED **");
    $finish;
  end

endmodule
